>>> rtl/cdl_pkg.sv
// cdl_pkg: widths, constants, config register codes and the generator step
// function shared by the channel dropout block; no dependencies
package cdl_pkg;

  localparam int SAMPLE_W = 32;
  localparam int THRESH_W = 28;
  localparam int SCALE_W  = 24;
  localparam int CSIZE_W  = 17;
  localparam int GEN_W    = 28;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  localparam logic [GEN_W-1:0] LCG_MODULUS = GEN_W'(214748387);
  localparam logic [6:0]       LCG_MULT    = 7'd75;
  localparam logic [GEN_W-1:0] LCG_SEED    = GEN_W'(10);

  localparam logic [THRESH_W-1:0] THRESH_RESET = '0;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(65536);
  localparam logic [CSIZE_W-1:0]  CSIZE_RESET  = CSIZE_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_THRESHOLD = 2'd0,
    CFG_KEEP_SCALE     = 2'd1,
    CFG_CHANNEL_SIZE   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [THRESH_W-1:0] drop_threshold;
    logic [SCALE_W-1:0]  keep_scale;
    logic [CSIZE_W-1:0]  channel_size;
  } cfg_t;

  // x * 75 mod modulus; quotient estimated as floor(p * 10 / 2^31), which is
  // exact or one too high, so one conditional add of the modulus fixes it
  function automatic logic [GEN_W-1:0] lcg_next(input logic [GEN_W-1:0] x);
    logic [GEN_W+6:0]  p;
    logic [GEN_W+10:0] p10;
    logic [7:0]        q_est;
    logic [GEN_W+7:0]  qm;
    logic [GEN_W+8:0]  r;
    p     = x * LCG_MULT;
    p10   = ({4'd0, p} << 3) + ({4'd0, p} << 1);
    q_est = p10[GEN_W+10:GEN_W+3];
    qm    = q_est * LCG_MODULUS;
    r     = {2'd0, p} - {1'b0, qm};
    if (r[GEN_W+8]) begin
      r = r + {9'd0, LCG_MODULUS};
    end
    return r[GEN_W-1:0];
  endfunction

endpackage

>>> rtl/cdl_if.sv
// cdl_in_if and cdl_out_if: valid/ready stream channels of the dropout block
// depends on cdl_pkg
interface cdl_in_if import cdl_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       tensor_start;

  modport source (output valid, output sample_in, output tensor_start, input ready);
  modport sink (input valid, input sample_in, input tensor_start, output ready);
endinterface

interface cdl_out_if import cdl_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       channel_dropped;

  modport source (output valid, output sample_out, output channel_dropped, input ready);
  modport sink (input valid, input sample_out, input channel_dropped, output ready);
endinterface

>>> rtl/cdl_lcg.sv
// cdl_lcg: generator value, position inside the channel and drop decision
// depends on cdl_pkg
module cdl_lcg import cdl_pkg::*; #(
  parameter int MAX_CHANNEL_ELEMENTS = 65536
) (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  logic tensor_start,
  input  cfg_t cfg,
  output logic drop
);

  localparam int POS_W  = (MAX_CHANNEL_ELEMENTS > 1) ? $clog2(MAX_CHANNEL_ELEMENTS) : 1;
  localparam int SIZE_W = $clog2(MAX_CHANNEL_ELEMENTS + 1);
  localparam int CMP_W  = ((SIZE_W > CSIZE_W) ? SIZE_W : CSIZE_W) + 1;
  localparam logic [CMP_W-1:0] MAX_SIZE = CMP_W'(MAX_CHANNEL_ELEMENTS);

  logic [GEN_W-1:0] gen_r, gen_nxt, gen_cur, gen_step;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic             drop_r, drop_nxt;
  logic [CMP_W-1:0] size_raw, size_eff, pos_inc;
  logic             first;

  always_comb begin
    size_raw = CMP_W'(cfg.channel_size);
    if (size_raw == '0) begin
      size_eff = CMP_W'(1);
    end else if (size_raw > MAX_SIZE) begin
      size_eff = MAX_SIZE;
    end else begin
      size_eff = size_raw;
    end

    pos_cur  = tensor_start ? '0 : pos_r;
    gen_cur  = tensor_start ? LCG_SEED : gen_r;
    first    = (pos_cur == '0);
    gen_step = lcg_next(gen_cur);
    gen_nxt  = first ? gen_step : gen_cur;
    drop_nxt = first ? (gen_step < cfg.drop_threshold) : drop_r;

    pos_inc = CMP_W'(pos_cur) + CMP_W'(1);
    pos_nxt = (pos_inc >= size_eff) ? '0 : pos_inc[POS_W-1:0];
  end

  assign drop = drop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= LCG_SEED;
      pos_r  <= '0;
      drop_r <= 1'b0;
    end else if (advance) begin
      gen_r  <= gen_nxt;
      pos_r  <= pos_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

>>> rtl/cdl_scale.sv
// cdl_scale: Q16.16 sample times Q8.16 scale, round half up, saturate to 32 bits
// depends on cdl_pkg
module cdl_scale import cdl_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [SCALE_W-1:0]  scale,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int PROD_W = SAMPLE_W + SCALE_W + 1;
  localparam int Q_W    = PROD_W - 16;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(64'sd2147483647);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-64'sd2147483648);

  logic signed [PROD_W-1:0] prod, prod_rnd;
  logic signed [Q_W-1:0]    q;

  always_comb begin
    prod     = PROD_W'(sample) * $signed({1'b0, scale});
    prod_rnd = prod + PROD_W'(32768);
    q        = prod_rnd[PROD_W-1:16];
    if (q > Q_MAX) begin
      result = Q_MAX[SAMPLE_W-1:0];
    end else if (q < Q_MIN) begin
      result = Q_MIN[SAMPLE_W-1:0];
    end else begin
      result = q[SAMPLE_W-1:0];
    end
  end

endmodule

>>> rtl/channel_dropout_lcg_unit.sv
// channel_dropout_lcg_unit: channel-wise dropout over a channel-major stream
// depends on cdl_pkg, cdl_if, cdl_lcg, cdl_scale
//
// in_ch carries one signed Q16.16 element per transaction plus tensor_start,
// which reloads the generator seed and restarts the channel count. out_ch
// returns exactly one transaction per input element, in order: the element
// scaled by keep_scale (rounded, saturated) or zero with channel_dropped set.
// At the first element of every channel the generator steps once and the
// channel is dropped when the new value is below drop_threshold.
// cfg_we/cfg_index/cfg_wdata write drop_threshold (0), keep_scale (1) and
// channel_size (2); writes must go in only while the stream is idle, which
// the block itself does not enforce. Each element taken on in_ch passes the
// input register, then the generator step and the one 32x24 multiply, then
// the output register; one element per cycle moves while out_ch is ready.
// in_ch stays ready while out_ch stalls until both registers are full;
// nothing is lost or repeated under backpressure.
// Reset (synchronous, rst_n low) empties both registers, reloads seed 10,
// position 0 and the config reset values.
module channel_dropout_lcg_unit import cdl_pkg::*; #(
  parameter int MAX_CHANNEL_ELEMENTS = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cdl_in_if.sink                in_ch,
  cdl_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;

  logic                       in_valid_r;
  logic signed [SAMPLE_W-1:0] in_sample_r;
  logic                       in_start_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_dropped_r;

  logic                       advance, in_take, drop;
  logic signed [SAMPLE_W-1:0] scaled;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sample_out      = out_sample_r;
  assign out_ch.channel_dropped = out_dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drop_threshold <= THRESH_RESET;
      cfg_r.keep_scale     <= SCALE_RESET;
      cfg_r.channel_size   <= CSIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DROP_THRESHOLD: cfg_r.drop_threshold <= cfg_wdata[THRESH_W-1:0];
        CFG_KEEP_SCALE:     cfg_r.keep_scale     <= cfg_wdata[SCALE_W-1:0];
        CFG_CHANNEL_SIZE:   cfg_r.channel_size   <= cfg_wdata[CSIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sample_r <= in_ch.sample_in;
      in_start_r  <= in_ch.tensor_start;
    end
  end

  cdl_lcg #(
    .MAX_CHANNEL_ELEMENTS(MAX_CHANNEL_ELEMENTS)
  ) u_lcg (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .tensor_start (in_start_r),
    .cfg          (cfg_r),
    .drop         (drop)
  );

  cdl_scale u_scale (
    .sample (in_sample_r),
    .scale  (cfg_r.keep_scale),
    .result (scaled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample_r  <= drop ? '0 : scaled;
      out_dropped_r <= drop;
    end
  end

endmodule
